@@ design/string_hash_partitioner_defines.svh @@
// assertion macros for the string hash partitioner
`ifndef STRING_HASH_PARTITIONER_DEFINES_SVH
`define STRING_HASH_PARTITIONER_DEFINES_SVH

`ifndef ASSERT_OFF
// checked property, disabled while reset is asserted
`define SHP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("shp assertion failed");
// checked property, also checked while reset is asserted
`define SHP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("shp assertion failed");
`else
`define SHP_ASSERT(lbl, clk, rst_n, prop)
`define SHP_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

@@ design/shp_pkg.sv @@
// shared types and constants for the string hash partitioner
`timescale 1ns / 1ps

package shp_pkg;

    localparam int HASH_W  = 64;
    localparam int BYTE_W  = 8;
    localparam int CFG_W   = 17;
    localparam int IDX_W   = 16;
    localparam int CNT_W   = 6;

    localparam logic [HASH_W-1:0] HASH_SEED   = 64'd5381;
    localparam logic [CFG_W-1:0]  CFG_RESET   = 17'd1;
    localparam logic [CFG_W-1:0]  MAX_DIVISOR = 17'd65536;
    localparam logic [CNT_W-1:0]  DIV_LAST    = 6'd63;

    // operands for the shared adder
    typedef struct packed {
        logic [HASH_W-1:0] a;
        logic [HASH_W-1:0] b;
        logic              cin;
    } alu_req_t;

    typedef struct packed {
        logic [HASH_W-1:0] sum;
        logic              cout;
    } alu_rsp_t;

    // finished partition result from the engine
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] index;
    } res_t;

    // zero maps to one, anything above the maximum saturates
    function automatic logic [CFG_W-1:0] clamp_divisor(input logic [CFG_W-1:0] n);
        logic [CFG_W-1:0] d;
        d = n;
        if (n == '0)
        begin
            d = CFG_W'(1);
        end
        else if (n > MAX_DIVISOR)
        begin
            d = MAX_DIVISOR;
        end
        return d;
    endfunction

endpackage

@@ design/shp_if.sv @@
// valid/ready channel interfaces for key bytes, results and configuration
`timescale 1ns / 1ps

interface shp_key_if import shp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] key_byte;

    modport source (output valid, output key_byte, input ready);
    modport sink (input valid, input key_byte, output ready);
endinterface

interface shp_part_if import shp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] partition_index;

    modport source (output valid, output partition_index, input ready);
    modport sink (input valid, input partition_index, output ready);
endinterface

interface shp_cfg_if import shp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] part_count;

    modport source (output valid, output part_count, input ready);
    modport sink (input valid, input part_count, output ready);
endinterface

@@ design/string_hash_partitioner.sv @@
// top level: djb2 string hash with partition modulo
//
// channel    dir   payload                 handshake
// key        in    key_byte[7:0]           valid/ready
// partition  out   partition_index[15:0]   valid/ready
// cfg        in    part_count[16:0]        valid/ready, always ready
//
// a nonzero key byte passes through accept, shift-add of hash*32 + hash, add of the sign-extended byte
// a zero byte passes through accept, 64 restoring-division steps on the shared
// 64-bit adder (one hash bit per cycle), then hand-off to the output register
// the output register holds one result, so the next key is hashed while it waits;
// a second result stalls in the engine until the output register frees up
// reset sets the hash to 5381 and the partition count to 1; no clearing pass
`timescale 1ns / 1ps

module string_hash_partitioner import shp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    shp_key_if.sink   key,
    shp_part_if.source partition,
    shp_cfg_if.sink   cfg
);

    logic [CFG_W-1:0] part_count_reg;
    logic [CFG_W-1:0] divisor;
    logic             out_valid_reg;
    logic [IDX_W-1:0] out_index_reg;
    logic             res_ready;
    res_t             res;

    shp_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .key       (key),
        .divisor   (divisor),
        .res       (res),
        .res_ready (res_ready)
    );

    // configuration register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_count_reg <= CFG_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            part_count_reg <= cfg.part_count;
        end
    end

    assign divisor = clamp_divisor(part_count_reg);

    // output register decouples the engine from the result sink
    assign res_ready                 = !out_valid_reg || partition.ready;
    assign partition.valid           = out_valid_reg;
    assign partition.partition_index = out_index_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (partition.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid && res_ready)
        begin
            out_index_reg <= res.index;
        end
    end

endmodule

@@ design/shp_alu.sv @@
// shared 64-bit adder with carry in and carry out
`timescale 1ns / 1ps

module shp_alu import shp_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [HASH_W:0] total;

    // one wide add serves hash update and trial subtract
    always_comb
    begin
        total    = {1'b0, req.a} + {1'b0, req.b} + {{HASH_W{1'b0}}, req.cin};
        rsp.sum  = total[HASH_W-1:0];
        rsp.cout = total[HASH_W];
    end

endmodule

@@ design/shp_engine.sv @@
// sequencer for the djb2 hash update and the bit-serial modulo
`timescale 1ns / 1ps
`include "string_hash_partitioner_defines.svh"

module shp_engine import shp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    shp_key_if.sink          key,
    input  logic [CFG_W-1:0] divisor,
    output res_t             res,
    input  logic             res_ready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_DIV,
        S_FIN
    } state_t;

    state_t            state_reg, state_next;
    logic [HASH_W-1:0] hash_reg, hash_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic [IDX_W-1:0]  rem_reg, rem_next;
    logic [CFG_W-1:0]  div_reg, div_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    alu_req_t          alu_req;
    alu_rsp_t          alu_rsp;
    logic [IDX_W:0]    trial;
    logic              accept;

    shp_alu u_alu
    (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign key.ready = (state_reg == S_IDLE);
    assign accept    = key.valid && key.ready;
    assign res.valid = (state_reg == S_FIN);
    assign res.index = rem_reg;

    // next remainder candidate: old remainder with the next hash bit shifted in
    assign trial = {rem_reg, hash_reg[HASH_W-1]};

    // operand select for the shared adder
    always_comb
    begin
        alu_req = '0;
        unique case (state_reg)
            S_MUL:
            begin
                alu_req.a   = {hash_reg[HASH_W-6:0], 5'b0};
                alu_req.b   = hash_reg;
                alu_req.cin = 1'b0;
            end
            S_ADD:
            begin
                alu_req.a   = hash_reg;
                alu_req.b   = {{(HASH_W-BYTE_W){byte_reg[BYTE_W-1]}}, byte_reg};
                alu_req.cin = 1'b0;
            end
            S_DIV:
            begin
                alu_req.a   = {{(HASH_W-IDX_W-1){1'b0}}, trial};
                alu_req.b   = ~{{(HASH_W-CFG_W){1'b0}}, div_reg};
                alu_req.cin = 1'b1;
            end
            S_IDLE, S_FIN:
            begin
                alu_req = '0;
            end
            default:
            begin
                alu_req = '0;
            end
        endcase
    end

    // sequencer next-state and datapath updates
    always_comb
    begin
        state_next = state_reg;
        hash_next  = hash_reg;
        byte_next  = byte_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    byte_next = key.key_byte;
                    if (key.key_byte == '0)
                    begin
                        div_next   = divisor;
                        rem_next   = '0;
                        cnt_next   = '0;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                hash_next  = alu_rsp.sum;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                hash_next  = alu_rsp.sum;
                state_next = S_IDLE;
            end
            S_DIV:
            begin
                // carry out means the trial value is at least the divisor
                rem_next  = alu_rsp.cout ? alu_rsp.sum[IDX_W-1:0] : trial[IDX_W-1:0];
                hash_next = {hash_reg[HASH_W-2:0], 1'b0};
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (res_ready)
                begin
                    hash_next  = HASH_SEED;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            hash_reg  <= HASH_SEED;
            cnt_reg   <= '0;
            div_reg   <= CFG_RESET;
        end
        else
        begin
            state_reg <= state_next;
            hash_reg  <= hash_next;
            cnt_reg   <= cnt_next;
            div_reg   <= div_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        rem_reg  <= rem_next;
    end

    `SHP_ASSERT(a_zero_starts_div, clk, rst_n, (accept && key.key_byte == '0) |=> (state_reg == S_DIV && cnt_reg == '0))
    `SHP_ASSERT(a_rem_below_div, clk, rst_n, res.valid |-> ({1'b0, rem_reg} < div_reg))
    `SHP_ASSERT(a_seed_after_result, clk, rst_n, (res.valid && res_ready) |=> (hash_reg == HASH_SEED))
    `SHP_ASSERT(a_div_in_range, clk, rst_n, (state_reg == S_DIV) |-> (div_reg != '0 && div_reg <= MAX_DIVISOR))
    `SHP_ASSERT_ALWAYS(a_ready_excl_result, clk, !(key.ready && res.valid))

endmodule
